FILE: sv/gqg_pkg.sv
// shared types, constants and field layout of the glyph quad generator
`timescale 1ns / 1ps
package gqg_pkg;

  localparam int unsigned GLYPH_COUNT_DEF     = 128;
  localparam int unsigned COORD_FRAC_BITS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned METRICS_W = 48;
  localparam int unsigned TEX_W     = 64;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned SCALE_W   = 12;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned CORNER_W  = 3;

  localparam int unsigned OP_W   = 12;
  localparam int unsigned PROD_W = OP_W + SCALE_W + 1;

  localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN = -(2 ** (POS_W - 1));

  localparam logic [SCALE_W-1:0]  SCALE_RESET = SCALE_W'(256);
  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(5);

  // text run fields carried in the texcoord slot of a queue entry
  localparam int unsigned RUN_X_LSB = 0;
  localparam int unsigned RUN_Y_LSB = POS_W;
  localparam int unsigned RUN_S_LSB = 2 * POS_W;
  localparam int unsigned RUN_W     = 2 * POS_W + SCALE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_BEGIN = 2'd1,
    MODE_CHAR  = 2'd2
  } mode_e;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_CHAR  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [METRICS_W-1:0] metrics;
    logic [TEX_W-1:0]     tex;
  } entry_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } q_stat_t;

endpackage

FILE: sv/gqg_in_if.sv
// input item channel of the glyph quad generator
`timescale 1ns / 1ps
interface gqg_in_if;
  logic                                valid;
  logic                                ready;
  logic [gqg_pkg::MODE_W-1:0]          mode;
  logic [gqg_pkg::CODE_W-1:0]          char_code;
  logic [gqg_pkg::METRICS_W-1:0]       glyph_metrics;
  logic [gqg_pkg::TEX_W-1:0]           glyph_texcoords;
  logic                                glyph_present;
  logic signed [gqg_pkg::POS_W-1:0]    start_x;
  logic signed [gqg_pkg::POS_W-1:0]    start_y;
  logic [gqg_pkg::SCALE_W-1:0]         run_scale;

  modport source (
    output valid, mode, char_code, glyph_metrics, glyph_texcoords, glyph_present,
           start_x, start_y, run_scale,
    input  ready
  );
  modport sink (
    input  valid, mode, char_code, glyph_metrics, glyph_texcoords, glyph_present,
           start_x, start_y, run_scale,
    output ready
  );
endinterface

FILE: sv/gqg_out_if.sv
// vertex item channel of the glyph quad generator
`timescale 1ns / 1ps
interface gqg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gqg_pkg::POS_W-1:0]   vertex_x;
  logic signed [gqg_pkg::POS_W-1:0]   vertex_y;
  logic [gqg_pkg::COORD_W-1:0]        tex_u;
  logic [gqg_pkg::COORD_W-1:0]        tex_v;
  logic [gqg_pkg::CORNER_W-1:0]       corner;
  logic                               last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, tex_u, tex_v, corner, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, tex_u, tex_v, corner, last_vertex,
    output ready
  );
endinterface

FILE: sv/gqg_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module gqg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/gqg_front.sv
// front end: accepts items, keeps the glyph table, queues runs and valid characters
`timescale 1ns / 1ps
module gqg_front #(
  parameter int unsigned GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gqg_in_if.sink           in_i,
  input  gqg_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output gqg_pkg::entry_t  entry_o
);

  localparam int unsigned IDX_W = $clog2(GLYPH_COUNT);
  localparam logic [gqg_pkg::CODE_W:0] CODE_LIMIT = GLYPH_COUNT[gqg_pkg::CODE_W:0];
  localparam int unsigned ROW_W = gqg_pkg::METRICS_W + gqg_pkg::TEX_W;

  logic [GLYPH_COUNT-1:0]      valid_q;
  logic                        s1_valid_q;
  gqg_pkg::kind_e              s1_kind_q;
  logic [gqg_pkg::RUN_W-1:0]   s1_run_q;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic             tbl_we;
  logic             tbl_re;
  logic             is_begin;
  logic [ROW_W-1:0] rdata;

  assign in_i.ready = !s1_valid_q || !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = {1'b0, in_i.char_code} < CODE_LIMIT;
  assign idx        = in_i.char_code[IDX_W-1:0];
  assign is_begin   = in_i.mode == gqg_pkg::MODE_BEGIN;
  assign tbl_we     = accept && (in_i.mode == gqg_pkg::MODE_WRITE) && in_range;
  assign tbl_re     = accept && (in_i.mode == gqg_pkg::MODE_CHAR) && in_range && valid_q[idx];

  gqg_ram #(
    .WIDTH (ROW_W),
    .DEPTH (GLYPH_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (idx),
    .wdata_i ({in_i.glyph_metrics, in_i.glyph_texcoords}),
    .re_i    (tbl_re),
    .raddr_i (idx),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (tbl_we) begin
        valid_q[idx] <= in_i.glyph_present;
      end
      if (accept) begin
        s1_valid_q <= tbl_re || is_begin;
      end else if (push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q <= is_begin ? gqg_pkg::KIND_BEGIN : gqg_pkg::KIND_CHAR;
      s1_run_q  <= {in_i.run_scale, in_i.start_y, in_i.start_x};
    end
  end

  assign push_o = s1_valid_q && !q_stat_i.full;

  always_comb begin
    entry_o.kind = s1_kind_q;
    if (s1_kind_q == gqg_pkg::KIND_CHAR) begin
      entry_o.metrics = rdata[gqg_pkg::TEX_W +: gqg_pkg::METRICS_W];
      entry_o.tex     = rdata[gqg_pkg::TEX_W-1:0];
    end else begin
      entry_o.metrics = '0;
      entry_o.tex     = gqg_pkg::TEX_W'(s1_run_q);
    end
  end

endmodule

FILE: sv/gqg_queue.sv
// short queue between front end and quad builder
`timescale 1ns / 1ps
module gqg_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  gqg_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output gqg_pkg::q_stat_t stat_o,
  output gqg_pkg::entry_t  head_o
);

  localparam int unsigned PTR_W = $clog2(gqg_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(gqg_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(gqg_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(gqg_pkg::QUEUE_DEPTH - 1);

  gqg_pkg::entry_t  mem_q [gqg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign stat_o.full       = count_q == CNT_FULL;
  assign stat_o.head_valid = count_q != '0;
  assign head_o            = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: sv/gqg_back.sv
// back end: scales glyph metrics into a quad, moves the pen and emits six vertices
`timescale 1ns / 1ps
module gqg_back #(
  parameter int unsigned COORD_FRAC_BITS = gqg_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gqg_pkg::q_stat_t q_stat_i,
  input  gqg_pkg::entry_t  head_i,
  output logic             pop_o,
  gqg_out_if.source        out_o
);

  localparam int unsigned UP     = (COORD_FRAC_BITS >= 8) ? COORD_FRAC_BITS - 8 : 0;
  localparam int unsigned DN     = (COORD_FRAC_BITS < 8) ? 8 - COORD_FRAC_BITS : 0;
  localparam int unsigned TERM_W = gqg_pkg::PROD_W + UP;
  localparam int unsigned ACC_W  = TERM_W + 2;
  localparam int unsigned POS_W  = gqg_pkg::POS_W;
  localparam int unsigned CW     = gqg_pkg::COORD_W;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(gqg_pkg::POS_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(gqg_pkg::POS_MIN);

  // state names the scaled term held in the product register
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BX,
    ST_DEPTH,
    ST_WIDTH,
    ST_HEIGHT,
    ST_ADV
  } step_e;

  typedef struct packed {
    logic [POS_W-1:0] x0;
    logic [POS_W-1:0] y0;
    logic [POS_W-1:0] x1;
    logic [POS_W-1:0] y1;
    logic [CW-1:0]    u0;
    logic [CW-1:0]    v0;
    logic [CW-1:0]    u1;
    logic [CW-1:0]    v1;
  } quad_t;

  function automatic logic signed [gqg_pkg::OP_W-1:0] op_sel(
    logic [gqg_pkg::METRICS_W-1:0] m,
    step_e                         s
  );
    logic signed [gqg_pkg::OP_W-1:0] gw;
    logic signed [gqg_pkg::OP_W-1:0] gh;
    logic signed [gqg_pkg::OP_W-1:0] bx;
    logic signed [gqg_pkg::OP_W-1:0] by;
    logic signed [gqg_pkg::OP_W-1:0] adv;
    logic signed [gqg_pkg::OP_W-1:0] op;
    gw  = gqg_pkg::OP_W'({1'b0, m[7:0]});
    gh  = gqg_pkg::OP_W'({1'b0, m[15:8]});
    bx  = gqg_pkg::OP_W'($signed(m[23:16]));
    by  = gqg_pkg::OP_W'($signed(m[31:24]));
    adv = gqg_pkg::OP_W'({1'b0, m[47:38]});
    case (s)
      ST_BX:     op = bx;
      ST_DEPTH:  op = gh - by;
      ST_WIDTH:  op = gw;
      ST_HEIGHT: op = gh;
      ST_ADV:    op = adv;
      default:   op = '0;
    endcase
    return op;
  endfunction

  function automatic logic signed [POS_W-1:0] sat(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > ACC_MAX) begin
      c = ACC_MAX;
    end else if (v < ACC_MIN) begin
      c = ACC_MIN;
    end else begin
      c = v;
    end
    return c[POS_W-1:0];
  endfunction

  step_e                             state_q;
  logic                              res_valid_q;
  logic signed [POS_W-1:0]           pen_q;
  logic signed [POS_W-1:0]           base_q;
  logic [gqg_pkg::SCALE_W-1:0]       scale_q;
  logic signed [gqg_pkg::PROD_W-1:0] prod_q;
  logic [gqg_pkg::METRICS_W-1:0]     met_q;
  logic [gqg_pkg::TEX_W-1:0]         tex_q;
  logic signed [ACC_W-1:0]           x0_q;
  logic signed [ACC_W-1:0]           y0_q;
  logic signed [ACC_W-1:0]           x1_q;
  logic signed [ACC_W-1:0]           y1_q;
  quad_t                             res_q;

  logic                              em_valid_q;
  logic [gqg_pkg::CORNER_W-1:0]      corner_q;
  quad_t                             quad_q;

  step_e                             mul_st;
  logic [gqg_pkg::METRICS_W-1:0]     mul_met;
  logic signed [gqg_pkg::PROD_W-1:0] prod_d;
  logic signed [TERM_W-1:0]          prod_ext;
  logic signed [TERM_W-1:0]          term;
  logic signed [ACC_W-1:0]           term_acc;
  logic signed [ACC_W-1:0]           pen_ext;
  logic signed [ACC_W-1:0]           base_ext;
  logic                              out_accept;
  logic                              last;
  logic                              em_load;
  logic                              use_x1;
  logic                              use_y0;

  // operand for the next multiply
  always_comb begin
    mul_met = met_q;
    case (state_q)
      ST_IDLE: begin
        mul_st  = ST_BX;
        mul_met = head_i.metrics;
      end
      ST_BX:     mul_st = ST_DEPTH;
      ST_DEPTH:  mul_st = ST_WIDTH;
      ST_WIDTH:  mul_st = ST_HEIGHT;
      ST_HEIGHT: mul_st = ST_ADV;
      default:   mul_st = ST_IDLE;
    endcase
  end

  assign prod_d   = gqg_pkg::PROD_W'(op_sel(mul_met, mul_st) * $signed({1'b0, scale_q}));
  assign prod_ext = TERM_W'(prod_q);
  assign term     = (prod_ext <<< UP) >>> DN;
  assign term_acc = ACC_W'(term);
  assign pen_ext  = ACC_W'(pen_q);
  assign base_ext = ACC_W'(base_q);

  assign out_accept = out_o.valid && out_o.ready;
  assign last       = corner_q == gqg_pkg::LAST_CORNER;
  assign em_load    = res_valid_q && (!em_valid_q || (out_accept && last));

  assign pop_o = q_stat_i.head_valid && (state_q == ST_IDLE) &&
                 ((head_i.kind == gqg_pkg::KIND_BEGIN) || !res_valid_q || em_load);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      pen_q       <= '0;
      base_q      <= '0;
      scale_q     <= gqg_pkg::SCALE_RESET;
    end else begin
      prod_q <= prod_d;
      if (em_load) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            if (head_i.kind == gqg_pkg::KIND_CHAR) begin
              state_q <= ST_BX;
              met_q   <= head_i.metrics;
              tex_q   <= head_i.tex;
            end else begin
              pen_q   <= head_i.tex[gqg_pkg::RUN_X_LSB +: POS_W];
              base_q  <= head_i.tex[gqg_pkg::RUN_Y_LSB +: POS_W];
              scale_q <= head_i.tex[gqg_pkg::RUN_S_LSB +: gqg_pkg::SCALE_W];
            end
          end
        end
        ST_BX: begin
          x0_q    <= pen_ext + term_acc;
          state_q <= ST_DEPTH;
        end
        ST_DEPTH: begin
          y0_q    <= base_ext - term_acc;
          state_q <= ST_WIDTH;
        end
        ST_WIDTH: begin
          x1_q    <= x0_q + term_acc;
          state_q <= ST_HEIGHT;
        end
        ST_HEIGHT: begin
          y1_q    <= y0_q + term_acc;
          state_q <= ST_ADV;
        end
        ST_ADV: begin
          pen_q       <= sat(pen_ext + term_acc);
          res_q.x0    <= sat(x0_q);
          res_q.y0    <= sat(y0_q);
          res_q.x1    <= sat(x1_q);
          res_q.y1    <= sat(y1_q);
          res_q.u0    <= tex_q[0 +: CW];
          res_q.v0    <= tex_q[CW +: CW];
          res_q.u1    <= tex_q[2*CW +: CW];
          res_q.v1    <= tex_q[3*CW +: CW];
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // vertex emitter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      corner_q   <= '0;
    end else begin
      if (em_load) begin
        em_valid_q <= 1'b1;
        corner_q   <= '0;
        quad_q     <= res_q;
      end else if (out_accept) begin
        if (last) begin
          em_valid_q <= 1'b0;
        end else begin
          corner_q <= corner_q + gqg_pkg::CORNER_W'(1);
        end
      end
    end
  end

  assign use_x1 = corner_q inside {3'd2, 3'd4, 3'd5};
  assign use_y0 = corner_q inside {3'd1, 3'd2, 3'd4};

  assign out_o.valid       = em_valid_q;
  assign out_o.vertex_x    = use_x1 ? quad_q.x1 : quad_q.x0;
  assign out_o.vertex_y    = use_y0 ? quad_q.y0 : quad_q.y1;
  assign out_o.tex_u       = use_x1 ? quad_q.u1 : quad_q.u0;
  assign out_o.tex_v       = use_y0 ? quad_q.v1 : quad_q.v0;
  assign out_o.corner      = corner_q;
  assign out_o.last_vertex = last;

endmodule

FILE: sv/glyph_quad_generator.sv
// top level of the glyph quad generator
//
//   port   dir  item                                         handshake
//   in_i   in   glyph write, text run begin or character     valid / ready
//   out_o  out  one vertex: position, texcoord, corner       valid / ready
//
// writes and run begins are taken one per cycle while in_i is not stalled; a character
// with a valid glyph holds the quad builder (five scaled terms on one shared multiplier
// plus the pen update) and then the emitter for its six vertices, the two overlapping,
// so the builder can work on the next character while the emitter sends the last quad
// reset clears the glyph valid bits, pen and baseline to zero and the scale to 1.0
// in_i stalls only when the queue and front stage are full; out_o stalls hold the vertex
`timescale 1ns / 1ps
module glyph_quad_generator #(
  parameter int unsigned GLYPH_COUNT     = gqg_pkg::GLYPH_COUNT_DEF,
  parameter int unsigned COORD_FRAC_BITS = gqg_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gqg_in_if.sink    in_i,
  gqg_out_if.source out_o
);

  logic             push;
  logic             pop;
  gqg_pkg::entry_t  push_entry;
  gqg_pkg::entry_t  head_entry;
  gqg_pkg::q_stat_t q_stat;

  gqg_front #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  gqg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .stat_o  (q_stat),
    .head_o  (head_entry)
  );

  gqg_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .head_i   (head_entry),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // vertices of a quad follow in corner order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_vertex) |=>
      (out_o.valid && (out_o.corner == $past(out_o.corner) + 3'd1)))
    else $error("vertex corner sequence broken");

  // a new burst of vertices starts at the first corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> (out_o.corner == '0))
    else $error("quad output started mid-quad");

  // nothing leaves an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.head_valid)
    else $error("pop from empty queue");

endmodule

FILE: tb/glyph_quad_generator_tb.sv
// testbench of the glyph quad generator: directed and random items checked against a vertex predictor
`timescale 1ns / 1ps
module glyph_quad_generator_tb;

  localparam int GLYPHS      = int'(gqg_pkg::GLYPH_COUNT_DEF);
  localparam int FRAC        = int'(gqg_pkg::COORD_FRAC_BITS_DEF);
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 460;
  localparam int DRAIN_WAIT  = 30;

  localparam logic [gqg_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [gqg_pkg::MODE_W-1:0]       mode;
    logic [gqg_pkg::CODE_W-1:0]       code;
    logic [gqg_pkg::METRICS_W-1:0]    metrics;
    logic [gqg_pkg::TEX_W-1:0]        tex;
    logic                             present;
    logic signed [gqg_pkg::POS_W-1:0] sx;
    logic signed [gqg_pkg::POS_W-1:0] sy;
    logic [gqg_pkg::SCALE_W-1:0]      scale;
  } glyph_item_t;

  typedef struct {
    logic signed [gqg_pkg::POS_W-1:0] x;
    logic signed [gqg_pkg::POS_W-1:0] y;
    logic [gqg_pkg::COORD_W-1:0]      u;
    logic [gqg_pkg::COORD_W-1:0]      v;
    logic [gqg_pkg::CORNER_W-1:0]     corner;
    logic                             last;
  } vertex_t;

  logic clk_i;
  logic rst_ni;

  gqg_in_if  in_if ();
  gqg_out_if out_if ();

  glyph_quad_generator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [gqg_pkg::METRICS_W-1:0] glyph_metrics_mem [GLYPHS];
  logic [gqg_pkg::TEX_W-1:0]     glyph_tex_mem [GLYPHS];
  logic                          glyph_ok [GLYPHS];
  logic                          glyph_written [GLYPHS];
  longint                        pen_x;
  longint                        base_y;
  logic [gqg_pkg::SCALE_W-1:0]   run_scale_q;

  vertex_t vertices_due[$];

  int items_sent;
  int writes_seen;
  int runs_seen;
  int quads_due;
  int ignored_seen;
  int vertices_checked;
  int quads_checked;
  int mismatches;

  bit tx_idle_on;
  bit rx_idle_on;
  int hold_req;
  int hold_ack;
  int hold_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic longint scale_term(longint m);
    longint p;
    p = m * longint'(run_scale_q);
    if (FRAC >= 8) begin
      return p <<< (FRAC - 8);
    end
    return p >>> (8 - FRAC);
  endfunction

  function automatic logic signed [gqg_pkg::POS_W-1:0] clamp_pos(longint v);
    if (v > longint'(gqg_pkg::POS_MAX)) begin
      return gqg_pkg::POS_W'(gqg_pkg::POS_MAX);
    end
    if (v < longint'(gqg_pkg::POS_MIN)) begin
      return gqg_pkg::POS_W'(gqg_pkg::POS_MIN);
    end
    return v[gqg_pkg::POS_W-1:0];
  endfunction

  task automatic add_vertex(input int k, input longint x, input longint y,
                            input logic [gqg_pkg::COORD_W-1:0] u,
                            input logic [gqg_pkg::COORD_W-1:0] v);
    vertex_t vx;
    vx.x      = clamp_pos(x);
    vx.y      = clamp_pos(y);
    vx.u      = u;
    vx.v      = v;
    vx.corner = gqg_pkg::CORNER_W'(k);
    vx.last   = (gqg_pkg::CORNER_W'(k) == gqg_pkg::LAST_CORNER);
    vertices_due.insert(vertices_due.size(), vx);
  endtask

  task automatic predict_quad(input glyph_item_t it);
    logic [gqg_pkg::METRICS_W-1:0] m;
    logic [gqg_pkg::TEX_W-1:0]     t;
    longint gw, gh, bx, by, adv, x0, y0, x1, y1;
    m   = glyph_metrics_mem[it.code];
    t   = glyph_tex_mem[it.code];
    gw  = longint'(m[7:0]);
    gh  = longint'(m[15:8]);
    bx  = longint'($signed(m[23:16]));
    by  = longint'($signed(m[31:24]));
    adv = longint'(m[47:32] >> 6);
    x0  = pen_x + scale_term(bx);
    y0  = base_y - scale_term(gh - by);
    x1  = x0 + scale_term(gw);
    y1  = y0 + scale_term(gh);
    add_vertex(0, x0, y1, t[15:0], t[31:16]);
    add_vertex(1, x0, y0, t[15:0], t[63:48]);
    add_vertex(2, x1, y0, t[47:32], t[63:48]);
    add_vertex(3, x0, y1, t[15:0], t[31:16]);
    add_vertex(4, x1, y0, t[47:32], t[63:48]);
    add_vertex(5, x1, y1, t[47:32], t[31:16]);
    pen_x = longint'(clamp_pos(pen_x + scale_term(adv)));
    quads_due++;
  endtask

  task automatic predict_item(input glyph_item_t it);
    if (it.mode == gqg_pkg::MODE_WRITE && it.code < GLYPHS) begin
      glyph_metrics_mem[it.code] = it.metrics;
      glyph_tex_mem[it.code]     = it.tex;
      glyph_ok[it.code]          = it.present;
      glyph_written[it.code]     = 1'b1;
      writes_seen++;
    end else if (it.mode == gqg_pkg::MODE_BEGIN) begin
      pen_x       = longint'(it.sx);
      base_y      = longint'(it.sy);
      run_scale_q = it.scale;
      runs_seen++;
    end else if (it.mode == gqg_pkg::MODE_CHAR && it.code < GLYPHS && glyph_ok[it.code]) begin
      predict_quad(it);
    end else begin
      ignored_seen++;
    end
  endtask

  task automatic send_item(input glyph_item_t it);
    while (tx_idle_on && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.mode            <= it.mode;
    in_if.char_code       <= it.code;
    in_if.glyph_metrics   <= it.metrics;
    in_if.glyph_texcoords <= it.tex;
    in_if.glyph_present   <= it.present;
    in_if.start_x         <= it.sx;
    in_if.start_y         <= it.sy;
    in_if.run_scale       <= it.scale;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_item(it);
    items_sent++;
  endtask

  function automatic glyph_item_t random_item();
    glyph_item_t it;
    it.mode    = gqg_pkg::MODE_W'($urandom);
    it.code    = gqg_pkg::CODE_W'($urandom);
    it.metrics = {16'($urandom), 32'($urandom)};
    it.tex     = {32'($urandom), 32'($urandom)};
    it.present = 1'($urandom);
    it.sx      = gqg_pkg::POS_W'($urandom);
    it.sy      = gqg_pkg::POS_W'($urandom);
    it.scale   = gqg_pkg::SCALE_W'($urandom);
    return it;
  endfunction

  function automatic glyph_item_t glyph_write(input logic [gqg_pkg::CODE_W-1:0] code,
                                              input logic [gqg_pkg::METRICS_W-1:0] metrics,
                                              input logic [gqg_pkg::TEX_W-1:0] tex,
                                              input logic present);
    glyph_item_t it;
    it         = random_item();
    it.mode    = gqg_pkg::MODE_WRITE;
    it.code    = code;
    it.metrics = metrics;
    it.tex     = tex;
    it.present = present;
    return it;
  endfunction

  function automatic glyph_item_t run_begin(input logic signed [gqg_pkg::POS_W-1:0] sx,
                                            input logic signed [gqg_pkg::POS_W-1:0] sy,
                                            input logic [gqg_pkg::SCALE_W-1:0] scale);
    glyph_item_t it;
    it       = random_item();
    it.mode  = gqg_pkg::MODE_BEGIN;
    it.sx    = sx;
    it.sy    = sy;
    it.scale = scale;
    return it;
  endfunction

  function automatic glyph_item_t glyph_char(input logic [gqg_pkg::CODE_W-1:0] code);
    glyph_item_t it;
    it      = random_item();
    it.mode = gqg_pkg::MODE_CHAR;
    it.code = code;
    return it;
  endfunction

  function automatic logic [gqg_pkg::CODE_W-1:0] written_code();
    logic [gqg_pkg::CODE_W-1:0] c;
    c = gqg_pkg::CODE_W'($urandom_range(GLYPHS - 1));
    while (!glyph_written[c]) begin
      c = gqg_pkg::CODE_W'($urandom_range(GLYPHS - 1));
    end
    return c;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatches < 10) begin
      $display("%t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(rx_idle_on && $urandom_range(99) < 8);
    end
  end

  always @(posedge clk_i) begin
    vertex_t exp_v;
    string   bad;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (vertices_due.size() == 0) begin
        note_failure($sformatf("unexpected vertex x=%0d y=%0d corner=%0d",
                               out_if.vertex_x, out_if.vertex_y, out_if.corner));
      end else begin
        exp_v = vertices_due.pop_front();
        bad   = "";
        if (out_if.vertex_x !== exp_v.x) bad = {bad, " vertex_x"};
        if (out_if.vertex_y !== exp_v.y) bad = {bad, " vertex_y"};
        if (out_if.tex_u !== exp_v.u) bad = {bad, " tex_u"};
        if (out_if.tex_v !== exp_v.v) bad = {bad, " tex_v"};
        if (out_if.corner !== exp_v.corner) bad = {bad, " corner"};
        if (out_if.last_vertex !== exp_v.last) bad = {bad, " last_vertex"};
        if (bad != "") begin
          note_failure($sformatf({"vertex mismatch on%s: expected x=%0d y=%0d u=%h v=%h ",
                                  "corner=%0d last=%b, got x=%0d y=%0d u=%h v=%h ",
                                  "corner=%0d last=%b"}, bad,
                                 exp_v.x, exp_v.y, exp_v.u, exp_v.v, exp_v.corner,
                                 exp_v.last, out_if.vertex_x, out_if.vertex_y,
                                 out_if.tex_u, out_if.tex_v, out_if.corner,
                                 out_if.last_vertex));
        end
        vertices_checked++;
        if (out_if.last_vertex === 1'b1) quads_checked++;
      end
    end
  end

  task automatic test_glyph_writes();
    // ordinary glyph: 10x12, bearing (1,10), advance 8 px
    send_item(glyph_write(8'd0, {16'd512, 8'd10, 8'd1, 8'd12, 8'd10},
                          64'h2000_1800_1000_0800, 1'b1));
    // every metric bit set, texcoords all ones
    send_item(glyph_write(8'd127, {gqg_pkg::METRICS_W{1'b1}}, {gqg_pkg::TEX_W{1'b1}}, 1'b1));
    // zero width, most negative x bearing, most positive y bearing
    send_item(glyph_write(8'd5, {16'd64, 8'd127, 8'h80, 8'd40, 8'd0}, '0, 1'b1));
    // out of table writes
    send_item(glyph_write(8'd128, {gqg_pkg::METRICS_W{1'b1}}, '0, 1'b1));
    send_item(glyph_write(8'd255, '0, {gqg_pkg::TEX_W{1'b1}}, 1'b1));
    // entry written but not present
    send_item(glyph_write(8'd9, {16'd256, 8'd4, 8'd2, 8'd8, 8'd6}, 64'h1234_5678_9abc_def0,
                          1'b0));
  endtask

  task automatic test_text_runs();
    send_item(run_begin('0, '0, gqg_pkg::SCALE_RESET));
    send_item(glyph_char(8'd0));
    send_item(glyph_char(8'd5));
    send_item(glyph_char(8'd127));
    // positive saturation at the largest scale
    send_item(run_begin(gqg_pkg::POS_W'(gqg_pkg::POS_MAX), gqg_pkg::POS_W'(gqg_pkg::POS_MAX),
                        {gqg_pkg::SCALE_W{1'b1}}));
    send_item(glyph_char(8'd127));
    send_item(glyph_char(8'd0));
    // negative saturation
    send_item(run_begin(gqg_pkg::POS_W'(gqg_pkg::POS_MIN), gqg_pkg::POS_W'(gqg_pkg::POS_MIN),
                        {gqg_pkg::SCALE_W{1'b1}}));
    send_item(glyph_char(8'd5));
    // zero scale collapses the quad to the pen
    send_item(run_begin(24'sd25600, -24'sd12800, '0));
    send_item(glyph_char(8'd0));
  endtask

  task automatic test_ignored_items();
    glyph_item_t it;
    send_item(glyph_char(8'd9));
    send_item(glyph_char(8'd200));
    send_item(glyph_char(8'd128));
    it      = random_item();
    it.mode = MODE_UNUSED;
    send_item(it);
    // the same entry once made present
    send_item(glyph_write(8'd9, {16'd256, 8'd4, 8'd2, 8'd8, 8'd6}, 64'h1234_5678_9abc_def0,
                          1'b1));
    send_item(glyph_char(8'd9));
  endtask

  task automatic test_backpressure();
    send_item(run_begin(24'sd2560, 24'sd5120, gqg_pkg::SCALE_RESET));
    hold_req++;
    repeat (24) send_item(glyph_char(written_code()));
  endtask

  function automatic glyph_item_t random_glyph_write();
    glyph_item_t it;
    it = random_item();
    it.mode = gqg_pkg::MODE_WRITE;
    if ($urandom_range(9) != 0) it.code[gqg_pkg::CODE_W-1] = 1'b0;
    it.present = ($urandom_range(9) != 0);
    if ($urandom_range(3) != 0) it.metrics[47:32] = 16'($urandom_range(64 * 64));
    return it;
  endfunction

  function automatic glyph_item_t random_run_begin();
    glyph_item_t it;
    it = random_item();
    it.mode = gqg_pkg::MODE_BEGIN;
    if ($urandom_range(3) != 0) begin
      it.sx    = gqg_pkg::POS_W'(int'($urandom_range(1 << 21)) - (1 << 20));
      it.sy    = gqg_pkg::POS_W'(int'($urandom_range(1 << 21)) - (1 << 20));
      it.scale = gqg_pkg::SCALE_W'($urandom_range(64, 1024));
    end
    return it;
  endfunction

  function automatic glyph_item_t random_noise();
    glyph_item_t it;
    it = random_item();
    case ($urandom_range(2))
      0: it.mode = MODE_UNUSED;
      1: begin
        it.mode = gqg_pkg::MODE_CHAR;
        it.code[gqg_pkg::CODE_W-1] = 1'b1;
      end
      default: begin
        it.mode = gqg_pkg::MODE_CHAR;
        it.code = written_code();
      end
    endcase
    return it;
  endfunction

  task automatic test_random_text();
    int pick;
    int n;
    n = 0;
    while (items_sent < ITEM_TARGET) begin
      if (n == 150) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else if (n == 260) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 8) send_item(random_glyph_write());
      else if (pick < 18) send_item(random_run_begin());
      else if (pick < 23) send_item(random_noise());
      else send_item(glyph_char(written_code()));
      n++;
    end
  endtask

  initial begin
    rst_ni                 = 1'b0;
    in_if.valid           <= 1'b0;
    in_if.mode            <= gqg_pkg::MODE_WRITE;
    in_if.char_code       <= '0;
    in_if.glyph_metrics   <= '0;
    in_if.glyph_texcoords <= '0;
    in_if.glyph_present   <= 1'b0;
    in_if.start_x         <= '0;
    in_if.start_y         <= '0;
    in_if.run_scale       <= '0;
    for (int i = 0; i < GLYPHS; i++) begin
      glyph_metrics_mem[i] = '0;
      glyph_tex_mem[i]     = '0;
      glyph_ok[i]          = 1'b0;
      glyph_written[i]     = 1'b0;
    end
    pen_x       = 0;
    base_y      = 0;
    run_scale_q = gqg_pkg::SCALE_RESET;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_glyph_writes();
    test_text_runs();
    test_ignored_items();
    test_backpressure();
    test_random_text();

    in_if.valid <= 1'b0;
    while (vertices_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (vertices_due.size() != 0) begin
      note_failure($sformatf("%0d vertices never arrived", vertices_due.size()));
    end

    $display("sent %0d items: %0d glyph writes, %0d text runs, %0d quads, %0d ignored",
             items_sent, writes_seen, runs_seen, quads_due, ignored_seen);
    $display("checked %0d vertices in %0d quads, %0d mismatches",
             vertices_checked, quads_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
